// ===== rtl/effect_slot_pool_manager_assert.svh =====
// assertion macros for the effect slot pool manager checker
// no dependencies; included by the checker file
`ifndef EFFECT_SLOT_POOL_MANAGER_ASSERT_SVH
`define EFFECT_SLOT_POOL_MANAGER_ASSERT_SVH

// same-cycle implication
`define ESPM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("espm assertion failed");

// next-cycle implication
`define ESPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("espm assertion failed");

`endif

// ===== rtl/espm_pkg.sv =====
// shared types, codes and constants of the effect slot pool manager
// no dependencies; used by the ram, the top level and the checker of the block
package espm_pkg;

    localparam int SLOT_COUNT_DEF = 40;
    localparam int MARK_W         = 2;
    localparam int STATUS_W       = 5;
    localparam int ASSIGNED_W     = 6;
    localparam int TDATA_W        = 24;

    localparam logic [7:0] FIRST_SLOT = 8'h01;
    localparam logic [7:0] ID_ALL     = 8'hFF;
    localparam logic [7:0] ID_ALL_OP  = 8'h7F;

    localparam logic [MARK_W-1:0] MARK_ALLOC = 2'b01;
    localparam logic [MARK_W-1:0] MARK_PLAY  = 2'b10;

    localparam logic [STATUS_W-1:0] STAT_PAUSED  = 5'h01;
    localparam logic [STATUS_W-1:0] STAT_ENABLED = 5'h02;
    localparam logic [STATUS_W-1:0] STAT_SAFETY  = 5'h04;
    localparam logic [STATUS_W-1:0] STAT_POWER   = 5'h10;

    localparam logic [7:0] CTL_DISABLE  = 8'd1;
    localparam logic [7:0] CTL_ENABLE   = 8'd2;
    localparam logic [7:0] CTL_STOP_ALL = 8'd3;
    localparam logic [7:0] CTL_RESET    = 8'd4;
    localparam logic [7:0] CTL_PAUSE    = 8'd5;
    localparam logic [7:0] CTL_CONTINUE = 8'd6;

    localparam logic [1:0] AC_NONE    = 2'd0;
    localparam logic [1:0] AC_DISABLE = 2'd1;
    localparam logic [1:0] AC_ENABLE  = 2'd2;

    typedef enum logic [2:0] {
        OP_CREATE     = 3'd0,
        OP_START      = 3'd1,
        OP_START_SOLO = 3'd2,
        OP_STOP       = 3'd3,
        OP_FREE       = 3'd4,
        OP_DEV_CTRL   = 3'd5,
        OP_POOL_RESET = 3'd6,
        OP_NOP        = 3'd7
    } opcode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIND,
        S_SWEEP,
        S_TOUCH_RD,
        S_TOUCH_WR,
        S_FLAG_RD,
        S_FLAG_CHK,
        S_OUT
    } state_t;

    function automatic logic id_in_range(input logic [7:0] id, input logic [7:0] max_id);
        return (id >= FIRST_SLOT) && (id <= max_id);
    endfunction

endpackage

// ===== rtl/espm_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies beyond espm_pkg for default sizes
module espm_ram #(
    parameter int WIDTH = espm_pkg::MARK_W,
    parameter int DEPTH = espm_pkg::SLOT_COUNT_DEF + 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/effect_slot_pool_manager.sv =====
// top level of the effect slot pool manager: command sequencer and status register
// depends on espm_pkg and espm_ram
//
// usage:
// s_* channel takes one command per transaction; s_tdata holds opcode [2:0],
// effect_id [10:3], control_code [18:11], upper bits unused
// m_* channel gives one result per command; m_tdata holds assigned_id [5:0],
// pool_full [6], init_request [7], auto_center_request [9:8],
// device_status [14:10], slot_flags [16:15], upper bits zero
// one command is in flight at a time; s_tready is low from acceptance until
// the result transaction completes
// create scans the marks for a free slot; start solo and stop all sweep every
// slot; the slot scan reads one mark per cycle from the mark ram
// a stalled receiver holds the result and keeps s_tready low
// reset frees every slot at once through per-slot valid flip-flops and
// clears the status register; no clearing pass is needed
module effect_slot_pool_manager #(
    parameter int SLOT_COUNT = espm_pkg::SLOT_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [espm_pkg::TDATA_W-1:0] s_tdata,  // opcode, effect_id, control_code
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [espm_pkg::TDATA_W-1:0] m_tdata   // assigned_id, pool_full, init_request,
                                                   // auto_center_request, device_status,
                                                   // slot_flags
);

    localparam int DEPTH  = SLOT_COUNT + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(SLOT_COUNT + 2);
    localparam logic [7:0]       SLOT_MAX = 8'(SLOT_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT);

    espm_pkg::state_t  state_reg, state_next;
    espm_pkg::opcode_t op_reg, op_next;
    logic [7:0]        eid_reg, eid_next;
    logic [7:0]        ctl_reg, ctl_next;
    logic [espm_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [DEPTH-1:0]  valid_reg, valid_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic              vrd_reg;

    logic [espm_pkg::ASSIGNED_W-1:0] assigned_reg, assigned_next;
    logic                            full_reg, full_next;
    logic                            init_reg, init_next;
    logic [1:0]                      ac_reg, ac_next;
    logic [espm_pkg::MARK_W-1:0]     flags_reg, flags_next;

    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr, ram_raddr;
    logic [espm_pkg::MARK_W-1:0]  ram_wdata, ram_rdata;
    logic [espm_pkg::MARK_W-1:0]  rd_mark;

    logic [7:0]        op_id, tgt_id;
    logic              op_id_ok, tgt_ok, eid_ok;
    logic              idx_in;
    logic              found;
    logic [ADDR_W-1:0] prev_addr;
    logic              s_accept;

    assign s_tready = (state_reg == espm_pkg::S_IDLE);
    assign m_tvalid = (state_reg == espm_pkg::S_OUT);
    assign s_accept = s_tvalid && s_tready;

    assign op_id    = (eid_reg == espm_pkg::ID_ALL) ? espm_pkg::ID_ALL_OP : eid_reg;
    assign tgt_id   = (op_reg == espm_pkg::OP_START || op_reg == espm_pkg::OP_START_SOLO
                       || op_reg == espm_pkg::OP_STOP) ? op_id : eid_reg;
    assign op_id_ok = espm_pkg::id_in_range(op_id, SLOT_MAX);
    assign tgt_ok   = espm_pkg::id_in_range(tgt_id, SLOT_MAX);
    assign eid_ok   = espm_pkg::id_in_range(eid_reg, SLOT_MAX);

    assign idx_in    = (idx_reg <= IDX_LAST);
    assign prev_addr = ADDR_W'(idx_reg - IDX_W'(1));
    assign rd_mark   = vrd_reg ? ram_rdata : '0;
    assign found     = pend_reg && (rd_mark == '0);

    espm_ram #(
        .WIDTH (espm_pkg::MARK_W),
        .DEPTH (DEPTH)
    ) u_mark_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            espm_pkg::S_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = espm_pkg::S_DISPATCH;
                end
            end
            espm_pkg::S_DISPATCH:
            begin
                unique case (op_reg)
                    espm_pkg::OP_CREATE:     state_next = espm_pkg::S_FIND;
                    espm_pkg::OP_START,
                    espm_pkg::OP_STOP:       state_next = espm_pkg::S_TOUCH_RD;
                    espm_pkg::OP_START_SOLO: state_next = espm_pkg::S_SWEEP;
                    espm_pkg::OP_DEV_CTRL:
                    begin
                        if (ctl_reg == espm_pkg::CTL_STOP_ALL)
                        begin
                            state_next = espm_pkg::S_SWEEP;
                        end
                        else
                        begin
                            state_next = espm_pkg::S_FLAG_RD;
                        end
                    end
                    espm_pkg::OP_FREE,
                    espm_pkg::OP_POOL_RESET,
                    espm_pkg::OP_NOP:        state_next = espm_pkg::S_FLAG_RD;
                endcase
            end
            espm_pkg::S_FIND:
            begin
                if (found || !idx_in)
                begin
                    state_next = espm_pkg::S_OUT;
                end
            end
            espm_pkg::S_SWEEP:
            begin
                if (!idx_in)
                begin
                    state_next = (op_reg == espm_pkg::OP_START_SOLO) ?
                                 espm_pkg::S_TOUCH_RD : espm_pkg::S_FLAG_RD;
                end
            end
            espm_pkg::S_TOUCH_RD:
            begin
                state_next = op_id_ok ? espm_pkg::S_TOUCH_WR : espm_pkg::S_FLAG_RD;
            end
            espm_pkg::S_TOUCH_WR: state_next = espm_pkg::S_FLAG_RD;
            espm_pkg::S_FLAG_RD:  state_next = espm_pkg::S_FLAG_CHK;
            espm_pkg::S_FLAG_CHK: state_next = espm_pkg::S_OUT;
            espm_pkg::S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = espm_pkg::S_IDLE;
                end
            end
            default: state_next = espm_pkg::S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        op_next       = op_reg;
        eid_next      = eid_reg;
        ctl_next      = ctl_reg;
        status_next   = status_reg;
        valid_next    = valid_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        assigned_next = assigned_reg;
        full_next     = full_reg;
        init_next     = init_reg;
        ac_next       = ac_reg;
        flags_next    = flags_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = '0;
        unique case (state_reg)
            espm_pkg::S_IDLE:
            begin
                if (s_accept)
                begin
                    op_next       = espm_pkg::opcode_t'(s_tdata[2:0]);
                    eid_next      = s_tdata[10:3];
                    ctl_next      = s_tdata[18:11];
                    assigned_next = '0;
                    full_next     = 1'b0;
                    init_next     = 1'b0;
                    ac_next       = espm_pkg::AC_NONE;
                    flags_next    = '0;
                end
            end
            espm_pkg::S_DISPATCH:
            begin
                idx_next = IDX_W'(espm_pkg::FIRST_SLOT);
                unique case (op_reg)
                    espm_pkg::OP_FREE:
                    begin
                        if (eid_reg == espm_pkg::ID_ALL)
                        begin
                            valid_next = '0;
                        end
                        else if (eid_ok)
                        begin
                            valid_next[eid_reg[ADDR_W-1:0]] = 1'b0;
                        end
                    end
                    espm_pkg::OP_DEV_CTRL:
                    begin
                        status_next = status_reg | espm_pkg::STAT_SAFETY | espm_pkg::STAT_POWER;
                        unique case (ctl_reg)
                            espm_pkg::CTL_DISABLE:
                                status_next = status_next & ~espm_pkg::STAT_ENABLED;
                            espm_pkg::CTL_ENABLE:
                                status_next = status_next | espm_pkg::STAT_ENABLED;
                            espm_pkg::CTL_STOP_ALL:
                                ac_next = espm_pkg::AC_DISABLE;
                            espm_pkg::CTL_RESET:
                            begin
                                valid_next = '0;
                                ac_next    = espm_pkg::AC_ENABLE;
                            end
                            espm_pkg::CTL_PAUSE:
                                status_next = status_next | espm_pkg::STAT_PAUSED;
                            espm_pkg::CTL_CONTINUE:
                                status_next = status_next & ~espm_pkg::STAT_PAUSED;
                            default: ;
                        endcase
                    end
                    espm_pkg::OP_POOL_RESET:
                    begin
                        valid_next = '0;
                    end
                    espm_pkg::OP_CREATE,
                    espm_pkg::OP_START,
                    espm_pkg::OP_START_SOLO,
                    espm_pkg::OP_STOP,
                    espm_pkg::OP_NOP: ;
                endcase
            end
            espm_pkg::S_FIND:
            begin
                if (idx_in)
                begin
                    ram_raddr = idx_reg[ADDR_W-1:0];
                    pend_next = 1'b1;
                    idx_next  = idx_reg + IDX_W'(1);
                end
                if (found)
                begin
                    ram_we                = 1'b1;
                    ram_waddr             = prev_addr;
                    ram_wdata             = espm_pkg::MARK_ALLOC;
                    valid_next[prev_addr] = 1'b1;
                    assigned_next         = espm_pkg::ASSIGNED_W'(prev_addr);
                    flags_next            = espm_pkg::MARK_ALLOC;
                end
                else if (!idx_in)
                begin
                    full_next = 1'b1;
                end
            end
            espm_pkg::S_SWEEP:
            begin
                if (idx_in)
                begin
                    ram_raddr = idx_reg[ADDR_W-1:0];
                    pend_next = 1'b1;
                    idx_next  = idx_reg + IDX_W'(1);
                end
                if (pend_reg && vrd_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = prev_addr;
                    ram_wdata = ram_rdata & espm_pkg::MARK_ALLOC;
                end
            end
            espm_pkg::S_TOUCH_RD:
            begin
                if (op_id_ok)
                begin
                    ram_raddr = op_id[ADDR_W-1:0];
                end
            end
            espm_pkg::S_TOUCH_WR:
            begin
                if (rd_mark != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = op_id[ADDR_W-1:0];
                    if (op_reg == espm_pkg::OP_STOP)
                    begin
                        ram_wdata = rd_mark & espm_pkg::MARK_ALLOC;
                    end
                    else
                    begin
                        ram_wdata = rd_mark | espm_pkg::MARK_PLAY;
                        init_next = 1'b1;
                    end
                end
            end
            espm_pkg::S_FLAG_RD:
            begin
                if (tgt_ok)
                begin
                    ram_raddr = tgt_id[ADDR_W-1:0];
                end
            end
            espm_pkg::S_FLAG_CHK:
            begin
                flags_next = tgt_ok ? rd_mark : '0;
            end
            espm_pkg::S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= espm_pkg::S_IDLE;
            status_reg <= '0;
            valid_reg  <= '0;
            pend_reg   <= 1'b0;
            vrd_reg    <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            valid_reg  <= valid_next;
            pend_reg   <= pend_next;
            vrd_reg    <= valid_reg[ram_raddr];
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        eid_reg      <= eid_next;
        ctl_reg      <= ctl_next;
        assigned_reg <= assigned_next;
        full_reg     <= full_next;
        init_reg     <= init_next;
        ac_reg       <= ac_next;
        flags_reg    <= flags_next;
    end

    assign m_tdata = {7'b0, flags_reg, status_reg, ac_reg, init_reg, full_reg, assigned_reg};

endmodule

// ===== rtl/espm_checker.sv =====
// port-level checker of the effect slot pool manager, bound to the top level
// depends on effect_slot_pool_manager_assert.svh and espm_pkg
`include "effect_slot_pool_manager_assert.svh"

module espm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [espm_pkg::TDATA_W-1:0] m_tdata
);

    // stalled result transaction holds
    `ESPM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // busy right after a command transaction
    `ESPM_ASSERT_NEXT(a_busy_after_cmd, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // never ready for a command while a result is pending
    `ESPM_ASSERT_SAME(a_one_in_flight, clk, rst_n, m_tvalid, !s_tready)

    // full pool reports no slot
    `ESPM_ASSERT_SAME(a_full_no_id, clk, rst_n, m_tvalid && m_tdata[6], m_tdata[5:0] == 6'd0)

    // a started slot reads back allocated and playing
    `ESPM_ASSERT_SAME(a_init_playing, clk, rst_n, m_tvalid && m_tdata[7], m_tdata[16:15] == 2'b11)

endmodule

bind effect_slot_pool_manager espm_checker u_espm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/effect_slot_pool_manager_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the effect slot pool manager: directed and random commands
// the predictor keeps its own copy of the slot marks and the status bits
// depends on espm_pkg and the effect_slot_pool_manager rtl
module effect_slot_pool_manager_test;

    import espm_pkg::*;

    localparam int SLOTS        = SLOT_COUNT_DEF;
    localparam int STALL_LEN    = 400;
    localparam int SETTLE       = 64;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic [1:0]          slot_flags;
        logic [STATUS_W-1:0] device_status;
        logic [1:0]          auto_center_request;
        logic                init_request;
        logic                pool_full;
        logic [5:0]          assigned_id;
    } pool_result_t;

    logic                clk;
    logic                rst_n   = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;

    logic [MARK_W-1:0]   pool_marks [0:SLOTS] = '{default: '0};
    logic [STATUS_W-1:0] dev_status = '0;
    pool_result_t        pending_results [$];

    int  error_count   = 0;
    int  cycle_count   = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  stall_left    = 0;
    logic stall_req    = 1'b0;

    effect_slot_pool_manager dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic slot_addressable(input logic [7:0] id);
        return (id >= 8'd1) && (id <= 8'(SLOTS));
    endfunction

    function automatic logic begin_playback(input logic [7:0] id);
        if (!slot_addressable(id))
            return 1'b0;
        if (pool_marks[id] == '0)
            return 1'b0;
        pool_marks[id] = pool_marks[id] | MARK_PLAY;
        return 1'b1;
    endfunction

    function automatic pool_result_t predict_pool_command(input opcode_t op,
                                                          input logic [7:0] eid,
                                                          input logic [7:0] ctl);
        pool_result_t r;
        logic [7:0]   op_id;
        logic [7:0]   target;
        int           i;
        r = '0;
        op_id = (eid == ID_ALL) ? ID_ALL_OP : eid;
        case (op)
            OP_CREATE:
            begin
                for (i = 1; i <= SLOTS; i++)
                    if (r.assigned_id == '0 && pool_marks[i] == '0)
                    begin
                        pool_marks[i] = MARK_ALLOC;
                        r.assigned_id = i[5:0];
                    end
                r.pool_full = (r.assigned_id == '0);
                if (!r.pool_full)
                    r.slot_flags = pool_marks[r.assigned_id];
            end
            OP_START:
                r.init_request = begin_playback(op_id);
            OP_START_SOLO:
            begin
                for (i = 0; i <= SLOTS; i++)
                    pool_marks[i] = pool_marks[i] & MARK_ALLOC;
                r.init_request = begin_playback(op_id);
            end
            OP_STOP:
                if (slot_addressable(op_id))
                    if (pool_marks[op_id] != '0)
                        pool_marks[op_id] = pool_marks[op_id] & MARK_ALLOC;
            OP_FREE:
                if (eid == ID_ALL)
                    pool_marks = '{default: '0};
                else if (slot_addressable(eid))
                    pool_marks[eid] = '0;
            OP_DEV_CTRL:
            begin
                dev_status = dev_status | STAT_SAFETY | STAT_POWER;
                case (ctl)
                    CTL_DISABLE:  dev_status = dev_status & ~STAT_ENABLED;
                    CTL_ENABLE:   dev_status = dev_status | STAT_ENABLED;
                    CTL_STOP_ALL:
                    begin
                        for (i = 0; i <= SLOTS; i++)
                            pool_marks[i] = pool_marks[i] & MARK_ALLOC;
                        r.auto_center_request = AC_DISABLE;
                    end
                    CTL_RESET:
                    begin
                        pool_marks = '{default: '0};
                        r.auto_center_request = AC_ENABLE;
                    end
                    CTL_PAUSE:    dev_status = dev_status | STAT_PAUSED;
                    CTL_CONTINUE: dev_status = dev_status & ~STAT_PAUSED;
                    default:      ;
                endcase
            end
            OP_POOL_RESET:
                pool_marks = '{default: '0};
            default: ;
        endcase
        if (op != OP_CREATE)
        begin
            target = (op inside {OP_START, OP_START_SOLO, OP_STOP}) ? op_id : eid;
            r.slot_flags = slot_addressable(target) ? pool_marks[target] : '0;
        end
        r.device_status = dev_status;
        return r;
    endfunction

    // one command transaction; the expectation is recorded at acceptance
    task automatic issue_command(input opcode_t op, input logic [7:0] eid, input logic [7:0] ctl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, ctl, eid, op};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_pool_command(op, eid, ctl));
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
        if (exp != act)
        begin
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp, act);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        pool_result_t exp;
        pool_result_t act;
        if (rst_n && m_tvalid && m_tready)
        begin
            act = m_tdata[$bits(pool_result_t)-1:0];
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                exp = pending_results.pop_front();
                check_field("assigned_id", exp.assigned_id, act.assigned_id);
                check_field("pool_full", exp.pool_full, act.pool_full);
                check_field("init_request", exp.init_request, act.init_request);
                check_field("auto_center_request", exp.auto_center_request,
                            act.auto_center_request);
                check_field("device_status", exp.device_status, act.device_status);
                check_field("slot_flags", exp.slot_flags, act.slot_flags);
                check_field("unused bits", 0, m_tdata[TDATA_W-1:$bits(pool_result_t)]);
            end
        end
    end

    // result receiver with random holds and a long stall on request
    always @(posedge clk)
    begin
        if (stall_req)
            stall_left <= STALL_LEN;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        m_tready <= !stall_req && (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[effect_slot_pool_manager] ERROR");
            $finish;
        end
    end

    task automatic test_single_slot_commands();
        issue_command(OP_CREATE, 8'd0, 8'd0);
        issue_command(OP_START, 8'd1, 8'd0);
        issue_command(OP_START, ID_ALL, 8'd0);
        issue_command(OP_START, 8'd0, 8'd0);
        issue_command(OP_START, 8'd41, 8'd0);
        issue_command(OP_START, 8'd40, 8'd0);
        issue_command(OP_STOP, 8'd1, 8'd0);
        issue_command(OP_STOP, 8'd40, 8'd0);
        issue_command(OP_CREATE, 8'hFF, 8'hFF);
        issue_command(OP_START, 8'd2, 8'd0);
        issue_command(OP_START_SOLO, 8'd1, 8'd0);
        issue_command(OP_STOP, ID_ALL, 8'd0);
        issue_command(OP_START_SOLO, 8'd200, 8'd0);
        issue_command(OP_FREE, 8'd0, 8'd0);
        issue_command(OP_FREE, 8'd41, 8'd0);
        issue_command(OP_FREE, 8'd2, 8'd0);
        issue_command(OP_FREE, ID_ALL, 8'd0);
    endtask

    task automatic test_device_control();
        issue_command(OP_CREATE, 8'd0, 8'd0);
        issue_command(OP_START, 8'd1, 8'd0);
        issue_command(OP_DEV_CTRL, 8'd1, CTL_ENABLE);
        issue_command(OP_DEV_CTRL, 8'd1, CTL_PAUSE);
        issue_command(OP_DEV_CTRL, 8'd1, CTL_STOP_ALL);
        issue_command(OP_DEV_CTRL, 8'd0, CTL_CONTINUE);
        issue_command(OP_DEV_CTRL, ID_ALL, CTL_DISABLE);
        issue_command(OP_DEV_CTRL, 8'd1, 8'd0);
        issue_command(OP_DEV_CTRL, 8'd1, 8'hFF);
        issue_command(OP_DEV_CTRL, 8'd1, 8'd7);
        issue_command(OP_DEV_CTRL, 8'd1, CTL_RESET);
        issue_command(OP_CREATE, 8'd0, 8'd0);
        issue_command(OP_NOP, 8'd1, 8'hAA);
        issue_command(OP_POOL_RESET, 8'd1, 8'h55);
    endtask

    task automatic test_pool_exhaustion();
        int k;
        for (k = 0; k <= SLOTS; k++)
            issue_command(OP_CREATE, 8'($urandom_range(255)), 8'd0);
        issue_command(OP_START, 8'd40, 8'd0);
        issue_command(OP_FREE, 8'd17, 8'd0);
        issue_command(OP_CREATE, 8'd0, 8'd0);
        issue_command(OP_CREATE, 8'd0, 8'd0);
        issue_command(OP_POOL_RESET, 8'd0, 8'd0);
    endtask

    task automatic run_random_commands(input int count);
        int         k;
        int         pick;
        opcode_t    op;
        logic [7:0] eid;
        logic [7:0] ctl;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                op = OP_CREATE;
            else if (pick < 45)
                op = OP_START;
            else if (pick < 52)
                op = OP_START_SOLO;
            else if (pick < 64)
                op = OP_STOP;
            else if (pick < 77)
                op = OP_FREE;
            else if (pick < 92)
                op = OP_DEV_CTRL;
            else if (pick < 95)
                op = OP_POOL_RESET;
            else
                op = OP_NOP;
            pick = $urandom_range(99);
            if (pick < 75)
                eid = 8'($urandom_range(SLOTS, 1));
            else if (pick < 83)
                eid = ID_ALL;
            else if (pick < 90)
                eid = 8'($urandom_range(127, SLOTS + 1));
            else
                eid = 8'($urandom_range(255));
            if ($urandom_range(9) == 0)
                ctl = 8'($urandom_range(255));
            else
                ctl = 8'($urandom_range(6, 1));
            issue_command(op, eid, ctl);
        end
    endtask

    // receiver stalls long while commands keep coming
    task automatic test_receiver_stall();
        stall_req <= 1'b1;
        @(posedge clk);
        stall_req <= 1'b0;
        run_random_commands(10);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 32;
        recv_idle_pct = 60;
        test_single_slot_commands();
        test_device_control();
        test_pool_exhaustion();
        run_random_commands(280);
        test_receiver_stall();
        wait_until_drained();
        send_idle_pct = 60;
        recv_idle_pct = 32;
        run_random_commands(280);
        wait_until_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_commands(280);
        wait_until_drained();
        if (error_count == 0)
            $display("[effect_slot_pool_manager] OK");
        else
            $display("[effect_slot_pool_manager] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/espm_pkg.sv
rtl/espm_ram.sv
rtl/effect_slot_pool_manager.sv
rtl/espm_checker.sv
sim/effect_slot_pool_manager_test.sv
